@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MSP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MSP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MSP_ASSERT(label, clk, rst_n, prop, msg)

`define MSP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ rtl/msp_pkg.sv @@
package msp_pkg;

  localparam int DATA_W      = 32;
  localparam int STACK_IDX_W = 2;
  localparam int STATUS_W    = 2;
  localparam int NUM_SEL     = 1 << STACK_IDX_W;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

@@ rtl/msp_ifs.sv @@
interface msp_in_if;
  import msp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [STACK_IDX_W-1:0]   stack_index;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output mode, output stack_index, output push_value,
                  input ready);
  modport sink   (input valid, input mode, input stack_index, input push_value,
                  output ready);
endinterface

interface msp_out_if;
  import msp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] popped_value;

  modport source (output valid, output status, output popped_value, input ready);
  modport sink   (input valid, input status, input popped_value, output ready);
endinterface

@@ rtl/msp_ctrl.sv @@
`include "assert_macros.svh"

module msp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output msp_pkg::cmd_t cmd
);
  import msp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  assign in_ready    = (state_r == ST_IDLE);
  assign cmd.capture = (state_r == ST_IDLE) && in_valid;
  assign cmd.commit  = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MSP_ASSERT(a_capture_to_exec, clk, rst_n, cmd.capture |=> (state_r == ST_EXEC), "capture did not enter exec")
  `MSP_ASSERT(a_commit_result, clk, rst_n, cmd.commit |=> (state_r == ST_IDLE) && out_valid_r, "commit lost its result")
  `MSP_ASSERT(a_valid_from_commit, clk, rst_n, $rose(out_valid_r) |-> $past(cmd.commit), "result appeared without commit")

endmodule

@@ rtl/msp_dpath.sv @@
`include "assert_macros.svh"

module msp_dpath #(
  parameter int NUM_STACKS = 4,
  parameter int POOL_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  msp_pkg::cmd_t                     cmd,
  input  logic                              in_mode,
  input  logic [msp_pkg::STACK_IDX_W-1:0]   in_stack_index,
  input  logic signed [msp_pkg::DATA_W-1:0] in_push_value,
  output logic [msp_pkg::STATUS_W-1:0]      out_status,
  output logic signed [msp_pkg::DATA_W-1:0] out_popped_value
);
  import msp_pkg::*;

  localparam int LINK_W    = $clog2(POOL_DEPTH + 1);
  localparam int ADDR_W    = $clog2(POOL_DEPTH);
  localparam int TOP_DEPTH = (NUM_STACKS < NUM_SEL) ? NUM_STACKS : NUM_SEL;
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_DEPTH);

  logic [DATA_W-1:0]        data_mem [POOL_DEPTH];
  logic [LINK_W-1:0]        link_mem [POOL_DEPTH];

  logic [LINK_W-1:0]        stack_top_r [TOP_DEPTH];
  logic [LINK_W-1:0]        free_head_r;
  logic [LINK_W-1:0]        fill_r;

  logic                     mode_r;
  logic [STACK_IDX_W-1:0]   sel_r;
  logic signed [DATA_W-1:0] value_r;
  logic [ADDR_W-1:0]        slot_r;
  logic [LINK_W-1:0]        top_r;
  logic                     ok_r;
  logic                     fresh_r;
  logic [LINK_W-1:0]        link_rd_r;
  logic [DATA_W-1:0]        data_rd_r;
  logic [STATUS_W-1:0]      status_r;
  logic signed [DATA_W-1:0] popped_r;

  logic [LINK_W-1:0]        top_in;
  logic                     exists_in;
  logic [LINK_W-1:0]        cand;
  logic                     ok_in;
  logic [ADDR_W-1:0]        rd_addr;
  logic [LINK_W-1:0]        link_val;
  logic                     do_write;

  always_comb begin
    top_in = LINK_NULL;
    for (int i = 0; i < TOP_DEPTH; i++) begin
      if (in_stack_index == STACK_IDX_W'(i)) begin
        top_in = stack_top_r[i];
      end
    end
  end

  assign exists_in = (int'(in_stack_index) < NUM_STACKS);
  assign cand      = (in_mode == MODE_POP) ? top_in : free_head_r;
  assign ok_in     = exists_in && (cand < LINK_NULL);
  assign rd_addr   = ok_in ? cand[ADDR_W-1:0] : '0;
  assign link_val  = fresh_r ? (LINK_W'(slot_r) + LINK_W'(1)) : link_rd_r;
  assign do_write  = cmd.commit && ok_r;

  // untouched entries past the fill mark link to the next entry
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      link_rd_r <= link_mem[rd_addr];
      data_rd_r <= data_mem[rd_addr];
    end
    if (do_write) begin
      if (mode_r == MODE_PUSH) begin
        data_mem[slot_r] <= value_r;
        link_mem[slot_r] <= top_r;
      end else begin
        link_mem[slot_r] <= free_head_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      sel_r   <= in_stack_index;
      value_r <= in_push_value;
      slot_r  <= rd_addr;
      top_r   <= top_in;
      ok_r    <= ok_in;
      fresh_r <= (cand >= fill_r);
    end
    if (cmd.commit) begin
      if (ok_r) begin
        status_r <= STATUS_OK;
      end else if (mode_r == MODE_POP) begin
        status_r <= STATUS_EMPTY;
      end else begin
        status_r <= STATUS_FULL;
      end
      popped_r <= (ok_r && (mode_r == MODE_POP)) ? data_rd_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      fill_r      <= '0;
      for (int i = 0; i < TOP_DEPTH; i++) begin
        stack_top_r[i] <= LINK_NULL;
      end
    end else if (do_write) begin
      if (mode_r == MODE_PUSH) begin
        free_head_r <= link_val;
        if (fresh_r) begin
          fill_r <= fill_r + LINK_W'(1);
        end
        for (int i = 0; i < TOP_DEPTH; i++) begin
          if (sel_r == STACK_IDX_W'(i)) begin
            stack_top_r[i] <= LINK_W'(slot_r);
          end
        end
      end else begin
        free_head_r <= LINK_W'(slot_r);
        for (int i = 0; i < TOP_DEPTH; i++) begin
          if (sel_r == STACK_IDX_W'(i)) begin
            stack_top_r[i] <= link_val;
          end
        end
      end
    end
  end

  assign out_status       = status_r;
  assign out_popped_value = popped_r;

  `MSP_ASSERT(a_fill_bound, clk, rst_n, fill_r <= LINK_NULL, "fill mark past pool end")
  `MSP_ASSERT(a_free_head_range, clk, rst_n, (free_head_r <= fill_r) || (free_head_r == LINK_NULL), "free head beyond fill mark")
  `MSP_ASSERT(a_fresh_at_fill, clk, rst_n, (do_write && (mode_r == MODE_PUSH) && fresh_r) |-> (LINK_W'(slot_r) == fill_r), "fresh push not at fill mark")

endmodule

@@ rtl/multi_stack_shared_pool.sv @@
// Channel | Dir | Payload                            | Handshake
// in_if   | in  | mode, stack_index, push_value      | valid/ready
// out_if  | out | status, popped_value               | valid/ready
//
// Each request first picks the entry and reads its link and data from the pool
// memories, then writes back the links and the stack tops.
// A new request is taken once the previous one has been written back; the
// result waits in an output register and stalls the write back only while full.
// Reset is synchronous: all stacks empty, free list over the whole pool.
// No clearing pass: a fill mark stands in for the initial free-list links.
module multi_stack_shared_pool #(
  parameter int NUM_STACKS = 4,
  parameter int POOL_DEPTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  msp_in_if.sink    in_if,
  msp_out_if.source out_if
);
  import msp_pkg::*;

  cmd_t cmd;

  msp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  msp_dpath #(
    .NUM_STACKS (NUM_STACKS),
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_mode          (in_if.mode),
    .in_stack_index   (in_if.stack_index),
    .in_push_value    (in_if.push_value),
    .out_status       (out_if.status),
    .out_popped_value (out_if.popped_value)
  );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import msp_pkg::*;

  localparam int POOL_N      = 16;
  localparam int STACK_N     = 4;
  localparam int LINK_W      = 5;
  localparam int SLOT_W      = $clog2(POOL_N);
  localparam int NIL         = POOL_N;
  localparam int TOTAL_REQS  = 1700;
  localparam int QUIET_TAIL  = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   value;
  } stack_result_t;

  typedef struct packed {
    logic                   mode;
    logic [STACK_IDX_W-1:0] idx;
    logic [DATA_W-1:0]      val;
    logic                   typed;
    stack_result_t          want;
  } dir_row_t;

  localparam int DIR_N = 25;

  dir_row_t dir_tab [0:DIR_N-1] = '{
    '{MODE_POP,  2'd0, 32'h0000_0000, 1'b1, '{STATUS_EMPTY, 32'h0}},
    '{MODE_POP,  2'd1, 32'hFFFF_FFFF, 1'b1, '{STATUS_EMPTY, 32'h0}},
    '{MODE_POP,  2'd2, 32'h5555_5555, 1'b1, '{STATUS_EMPTY, 32'h0}},
    '{MODE_POP,  2'd3, 32'hAAAA_AAAA, 1'b1, '{STATUS_EMPTY, 32'h0}},
    '{MODE_PUSH, 2'd0, 32'h7FFF_FFFF, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd1, 32'h8000_0000, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd2, 32'h0000_0000, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd3, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd0, 32'h5555_5555, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd1, 32'hAAAA_AAAA, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd2, 32'h0000_0001, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd3, 32'hFFFF_FFFE, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd0, 32'h0000_0002, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd1, 32'h4000_0000, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd2, 32'hBFFF_FFFF, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd3, 32'h1234_5678, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd0, 32'h8765_4321, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd1, 32'h0000_FFFF, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd2, 32'hFFFF_0000, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd3, 32'h7FFF_FFFE, 1'b1, '{STATUS_OK, 32'h0}},
    '{MODE_PUSH, 2'd2, 32'h1357_9BDF, 1'b1, '{STATUS_FULL, 32'h0}},
    '{MODE_POP,  2'd3, 32'h0000_0000, 1'b0, '{STATUS_OK, 32'h0}},
    '{MODE_POP,  2'd0, 32'h0000_0000, 1'b0, '{STATUS_OK, 32'h0}},
    '{MODE_POP,  2'd1, 32'h0000_0000, 1'b0, '{STATUS_OK, 32'h0}},
    '{MODE_POP,  2'd2, 32'h0000_0000, 1'b0, '{STATUS_OK, 32'h0}}
  };

  logic clk;
  logic rst_n;

  msp_in_if  in_ch ();
  msp_out_if out_ch ();

  multi_stack_shared_pool dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  logic [DATA_W-1:0] pool_val  [POOL_N];
  logic [LINK_W-1:0] pool_next [POOL_N];
  logic [LINK_W-1:0] top_of    [STACK_N];
  logic [LINK_W-1:0] free_ptr;

  stack_result_t expected_results [$];
  int  sent_count     = 0;
  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  gap_pct        = 0;
  int  stall_pct      = 0;
  bit  quiet          = 1'b0;
  bit  long_hold      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic stack_result_t apply_stack_op(input logic m,
                                                   input logic [STACK_IDX_W-1:0] idx,
                                                   input logic [DATA_W-1:0] v);
    stack_result_t r;
    logic [SLOT_W-1:0] slot;
    r = '{STATUS_OK, '0};
    if (m == MODE_PUSH) begin
      if (int'(idx) >= STACK_N || int'(free_ptr) >= POOL_N) begin
        r.status = STATUS_FULL;
      end else begin
        slot            = free_ptr[SLOT_W-1:0];
        free_ptr        = pool_next[slot];
        pool_val[slot]  = v;
        pool_next[slot] = top_of[idx];
        top_of[idx]     = LINK_W'(slot);
      end
    end else begin
      if (int'(idx) >= STACK_N || int'(top_of[idx]) >= POOL_N) begin
        r.status = STATUS_EMPTY;
      end else begin
        slot            = top_of[idx][SLOT_W-1:0];
        top_of[idx]     = pool_next[slot];
        r.value         = pool_val[slot];
        pool_next[slot] = free_ptr;
        free_ptr        = LINK_W'(slot);
      end
    end
    return r;
  endfunction

  task automatic offer_request(input logic m, input logic [STACK_IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] v, input logic typed,
                               input stack_result_t typed_res);
    stack_result_t r;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.stack_index <= idx;
    in_ch.push_value  <= v;
    do @(posedge clk); while (!in_ch.ready);
    r = apply_stack_op(m, idx, v);
    expected_results.push_back(typed ? typed_res : r);
    sent_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: status=%0d value=%h", out_ch.status,
                   out_ch.popped_value);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.status !== want.status || out_ch.popped_value !== want.value) begin
          if (mismatch_count < 10)
            $display("mismatch at %0t: status exp %0d got %0d, value exp %h got %h",
                     $time, want.status, out_ch.status, want.value, out_ch.popped_value);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int                     seg_len;
    int                     push_pct;
    int                     pick;
    bit                     focused;
    logic [STACK_IDX_W-1:0] focus_idx;
    logic [STACK_IDX_W-1:0] idx;
    logic [DATA_W-1:0]      v;
    logic                   m;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_PUSH;
    in_ch.stack_index <= '0;
    in_ch.push_value  <= '0;

    for (int i = 0; i < POOL_N; i++) begin
      pool_val[i]  = '0;
      pool_next[i] = LINK_W'(i + 1);
    end
    for (int i = 0; i < STACK_N; i++) top_of[i] = LINK_W'(NIL);
    free_ptr = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    gap_pct   = 20;
    stall_pct = 15;
    for (int i = 0; i < DIR_N; i++)
      offer_request(dir_tab[i].mode, dir_tab[i].idx, dir_tab[i].val, dir_tab[i].typed,
                    dir_tab[i].want);

    while (sent_count < TOTAL_REQS) begin
      seg_len   = $urandom_range(8, 60);
      pick      = $urandom_range(0, 2);
      push_pct  = (pick == 0) ? 25 : (pick == 1) ? 50 : 80;
      focused   = ($urandom_range(0, 2) == 0);
      focus_idx = STACK_IDX_W'($urandom_range(0, STACK_N - 1));
      pick      = $urandom_range(0, 3);
      gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
      pick      = $urandom_range(0, 3);
      stall_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
      if (sent_count >= 700 && sent_count < 760) long_hold = 1'b1;
      for (int k = 0; k < seg_len; k++) begin
        if (sent_count >= TOTAL_REQS - QUIET_TAIL) quiet = 1'b1;
        m   = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
        idx = (focused && $urandom_range(0, 3) != 0) ?
              focus_idx : STACK_IDX_W'($urandom_range(0, STACK_N - 1));
        pick = $urandom_range(0, 15);
        case (pick)
          0: begin
            v = 32'h7FFF_FFFF;
          end
          1: begin
            v = 32'h8000_0000;
          end
          2: begin
            v = 32'h0000_0000;
          end
          3: begin
            v = 32'hFFFF_FFFF;
          end
          default: begin
            v = $urandom();
          end
        endcase
        offer_request(m, idx, v, 1'b0, '{STATUS_OK, '0});
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
